// ===== rtl/csem_pkg.sv =====
// Package for the counting semaphore table: sizes, codes and shared types.
package csem_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    // The free-entry search looks at one group of allocated flags per cycle.
    localparam int SCAN_W      = 8;
    localparam int SCAN_IW     = $clog2(SCAN_W);
    localparam int NUM_CHUNKS  = (NUM_ENTRIES + SCAN_W - 1) / SCAN_W;
    localparam int CHUNK_W     = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int SCAN_SPAN   = NUM_CHUNKS * SCAN_W;

    localparam int ACTION_W    = 2;
    localparam int HANDLE_W    = 8;
    localparam int COUNT_W     = 16;
    localparam int TASK_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int NH_W        = 4;

    localparam logic [HANDLE_W:0] HANDLE_LIMIT = (HANDLE_W + 1)'(NUM_ENTRIES);

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_POST  = 2'd1,
        ACT_ACQ   = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BLOCKED   = 3'd1,
        ST_BADHANDLE = 3'd2,
        ST_NOTALLOC  = 3'd3,
        ST_WAITING   = 3'd4,
        ST_FULL      = 3'd5,
        ST_OVERFLOW  = 3'd6
    } t_status;

    typedef enum logic {
        ALU_INC = 1'b0,
        ALU_DEC = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic [COUNT_W-1:0] sum;
        logic               at_max;
        logic               at_zero;
    } t_alu_res;

    // One word of the entry store: waiter id and count side by side.
    typedef struct packed {
        logic [TASK_W-1:0]  task_id;
        logic [COUNT_W-1:0] count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== rtl/csem_if.sv =====
// Valid/ready channel interfaces for semaphore requests and responses.
interface csem_req_if;
    import csem_pkg::*;

    logic                valid;
    logic                ready;
    t_action             action;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  init_count;
    logic [TASK_W-1:0]   task_id;

    modport source (output valid, action, handle, init_count, task_id, input ready);
    modport sink   (input valid, action, handle, init_count, task_id, output ready);
endinterface

interface csem_rsp_if;
    import csem_pkg::*;

    logic               valid;
    logic               ready;
    t_status            status;
    logic [NH_W-1:0]    new_handle;
    logic [COUNT_W-1:0] count_now;
    logic               woke;
    logic [TASK_W-1:0]  woken_task;

    modport source (output valid, status, new_handle, count_now, woke, woken_task,
                    input ready);
    modport sink   (input valid, status, new_handle, count_now, woke, woken_task,
                    output ready);
endinterface

// ===== rtl/csem_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/csem_alu.sv =====
// Shared count unit: increment or decrement, with at-max and at-zero flags on the operand.
module csem_alu (
    input  csem_pkg::t_alu_op               i_op,
    input  logic [csem_pkg::COUNT_W-1:0]    i_operand,
    output csem_pkg::t_alu_res              o_res
);
    import csem_pkg::*;

    always_comb begin
        o_res.at_max  = (i_operand == {COUNT_W{1'b1}});
        o_res.at_zero = (i_operand == '0);
        unique case (i_op)
            ALU_INC: o_res.sum = i_operand + COUNT_W'(1);
            ALU_DEC: o_res.sum = i_operand - COUNT_W'(1);
            default: o_res.sum = i_operand;
        endcase
    end
endmodule

// ===== rtl/counting_semaphore_table.sv =====
// Counting semaphore table: a request channel in, one response per request out.
// Requests arrive on i_req (valid/ready). Each carries an action (allocate,
// post, acquire or clear all), a handle, an initial count and a task id.
// Every accepted transaction produces exactly one response on o_rsp with a
// status, the new handle, the resulting count and any released waiter.
// Post, acquire and clear: the entry store is read in the accept cycle,
// the result is worked out in the execute state and the response is
// registered from there; a new request is taken only once this one is done.
// Allocate: the allocated flags are searched 8 entries per cycle, lowest
// first, and the response is registered from the scan state.
// i_req.ready is high only while the sequencer is idle.
// The response sits in an output register; if the receiver stalls, the next
// request is still accepted and worked on, and it waits at its last step
// until that register frees up.
// Reset clears the allocated and waiter flags, so every entry is free with
// a count of zero; the entry store itself needs no clearing pass, because
// an entry that is not allocated reads as a zero count.
module counting_semaphore_table (
    input logic       i_clk,
    input logic       i_rst_n,
    csem_req_if.sink  i_req,
    csem_rsp_if.source o_rsp
);
    import csem_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state              r_state, n_state;
    t_action             r_action;
    logic [HANDLE_W-1:0] r_handle;
    logic [COUNT_W-1:0]  r_init;
    logic [TASK_W-1:0]   r_task;
    logic [CHUNK_W-1:0]  r_chunk;
    logic [NUM_ENTRIES-1:0] r_alloc;
    logic [NUM_ENTRIES-1:0] r_waiter;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [NH_W-1:0]     r_out_nh;
    logic [COUNT_W-1:0]  r_out_cnt;
    logic                r_out_woke;
    logic [TASK_W-1:0]   r_out_wtask;

    logic                w_accept;
    logic                w_out_free;
    logic                w_fin;
    logic                w_done;
    t_entry              w_rdata;
    logic [IDX_W-1:0]    w_idx;
    logic                w_bad;
    logic                w_ent_alloc;
    logic                w_ent_wait;
    logic [COUNT_W-1:0]  w_count;
    t_alu_op             w_alu_op;
    t_alu_res            w_alu;

    logic [SCAN_SPAN-1:0] w_pad;
    logic [SCAN_W-1:0]   w_chunk;
    logic                w_found;
    logic [SCAN_IW-1:0]  w_sel;
    logic [CHUNK_W+SCAN_IW-1:0] w_scan_full;
    logic [IDX_W-1:0]    w_scan_idx;
    logic                w_last_chunk;

    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    t_entry              w_wdata;
    logic                w_set_alloc;
    logic                w_clr_all;
    logic                w_set_wait;
    logic                w_clr_wait;
    logic [IDX_W-1:0]    w_flag_idx;
    t_status             w_status;
    logic [NH_W-1:0]     w_nh;
    logic [COUNT_W-1:0]  w_cnt;
    logic                w_woke;
    logic [TASK_W-1:0]   w_wtask;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_done     = w_fin && w_out_free;

    csem_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we && w_out_free),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (i_req.handle[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Addressed entry; a free entry always reads as a zero count.
    assign w_idx       = r_handle[IDX_W-1:0];
    assign w_bad       = ({1'b0, r_handle} >= HANDLE_LIMIT);
    assign w_ent_alloc = r_alloc[w_idx];
    assign w_ent_wait  = r_waiter[w_idx];
    assign w_count     = w_ent_alloc ? w_rdata.count : '0;
    assign w_alu_op    = (r_action == ACT_POST) ? ALU_INC : ALU_DEC;

    csem_alu u_alu (
        .i_op      (w_alu_op),
        .i_operand (w_count),
        .o_res     (w_alu)
    );

    // Lowest free entry within the current group of flags.
    always_comb begin
        w_pad = '1;
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            w_pad[k] = r_alloc[k];
        end
        w_chunk = w_pad[{r_chunk, SCAN_IW'(0)} +: SCAN_W];
        w_found = 1'b0;
        w_sel   = '0;
        for (int j = SCAN_W - 1; j >= 0; j--) begin
            if (!w_chunk[j]) begin
                w_found = 1'b1;
                w_sel   = SCAN_IW'(j);
            end
        end
    end

    assign w_scan_full  = {r_chunk, w_sel};
    assign w_scan_idx   = w_scan_full[IDX_W-1:0];
    assign w_last_chunk = (r_chunk == CHUNK_W'(NUM_CHUNKS - 1));

    always_comb begin
        w_fin       = 1'b0;
        w_we        = 1'b0;
        w_waddr     = w_idx;
        w_wdata     = w_rdata;
        w_set_alloc = 1'b0;
        w_clr_all   = 1'b0;
        w_set_wait  = 1'b0;
        w_clr_wait  = 1'b0;
        w_flag_idx  = w_idx;
        w_status    = ST_OK;
        w_nh        = '0;
        w_cnt       = '0;
        w_woke      = 1'b0;
        w_wtask     = '0;
        priority if (r_state == S_SCAN) begin
            w_fin = w_found || w_last_chunk;
            if (w_found) begin
                w_we          = 1'b1;
                w_waddr       = w_scan_idx;
                w_wdata.task_id = '0;
                w_wdata.count = r_init;
                w_set_alloc   = 1'b1;
                w_clr_wait    = 1'b1;
                w_flag_idx    = w_scan_idx;
                w_nh          = NH_W'(w_scan_full);
                w_cnt         = r_init;
            end else begin
                w_status = ST_FULL;
            end
        end else if (r_state == S_EXEC) begin
            w_fin = 1'b1;
            priority if (r_action == ACT_CLEAR) begin
                w_clr_all = 1'b1;
            end else if (w_bad) begin
                w_status = ST_BADHANDLE;
            end else if (!w_ent_alloc) begin
                w_status = ST_NOTALLOC;
                w_cnt    = w_count;
            end else if (r_action == ACT_POST) begin
                w_cnt = w_count;
                priority if (w_ent_wait) begin
                    w_clr_wait = 1'b1;
                    w_woke     = 1'b1;
                    w_wtask    = w_rdata.task_id;
                end else if (w_alu.at_max) begin
                    w_status = ST_OVERFLOW;
                end else begin
                    w_we          = 1'b1;
                    w_wdata.count = w_alu.sum;
                    w_cnt         = w_alu.sum;
                end
            end else begin
                w_cnt = w_count;
                priority if (w_ent_wait) begin
                    w_status = ST_WAITING;
                end else if (!w_alu.at_zero) begin
                    w_we          = 1'b1;
                    w_wdata.count = w_alu.sum;
                    w_cnt         = w_alu.sum;
                end else begin
                    w_we            = 1'b1;
                    w_wdata.task_id = r_task;
                    w_set_wait      = 1'b1;
                    w_status        = ST_BLOCKED;
                end
            end
        end else begin
            w_fin = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req.action == ACT_ALLOC) ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chunk     <= '0;
            r_alloc     <= '0;
            r_waiter    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept || w_done) begin
                r_chunk <= '0;
            end else if (r_state == S_SCAN && !w_fin) begin
                r_chunk <= r_chunk + CHUNK_W'(1);
            end
            if (w_done) begin
                if (w_clr_all) begin
                    r_alloc  <= '0;
                    r_waiter <= '0;
                end
                if (w_set_alloc) begin
                    r_alloc[w_flag_idx] <= 1'b1;
                end
                if (w_set_wait) begin
                    r_waiter[w_flag_idx] <= 1'b1;
                end
                if (w_clr_wait) begin
                    r_waiter[w_flag_idx] <= 1'b0;
                end
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_req.action;
            r_handle <= i_req.handle;
            r_init   <= i_req.init_count;
            r_task   <= i_req.task_id;
        end
        if (w_done) begin
            r_out_status <= w_status;
            r_out_nh     <= w_nh;
            r_out_cnt    <= w_cnt;
            r_out_woke   <= w_woke;
            r_out_wtask  <= w_wtask;
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.new_handle = r_out_nh;
    assign o_rsp.count_now  = r_out_cnt;
    assign o_rsp.woke       = r_out_woke;
    assign o_rsp.woken_task = r_out_wtask;

`ifndef SYNTHESIS
    // A waiter can only be recorded on an allocated entry.
    a_waiter_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_waiter & ~r_alloc) == '0)
        else $error("waiter flag set on a free entry");

    // A released waiter is always reported with an ok status.
    a_woke_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_rsp.woke) |-> (o_rsp.status == ST_OK))
        else $error("wake reported with a failing status");

    // A successful allocate leaves the chosen entry allocated.
    a_alloc_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && w_set_alloc) |=> r_alloc[$past(w_flag_idx)])
        else $error("allocated entry not marked");

    // A response is only loaded by a request that is being worked on.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state != S_IDLE) && !i_req.ready)
        else $error("response loaded while idle");
`endif
endmodule
